// ===== hw/rtl/dp3d_pkg.sv =====
// Shared constants, register codes and types for the depth pixel back-projection block.
package dp3d_pkg;

  localparam int COORD_BITS = 12;

  localparam int DEPTH_W  = 16;
  localparam int COORD_W  = 12;
  localparam int CENTER_W = 13;
  localparam int RECIP_W  = 32;
  localparam int SCALE_W  = 32;
  localparam int XY_W     = 32;
  localparam int Z_W      = 31;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int NUM_STAGES = 5;

  localparam int PROD_W    = DEPTH_W + SCALE_W;
  localparam int Z_SHIFT   = 16;
  localparam int ZP_W      = PROD_W - Z_SHIFT;
  localparam int DIFF_W    = CENTER_W + 1;
  localparam int MAG_W     = CENTER_W;
  localparam int M_W       = MAG_W + Z_W;
  localparam int HALF_W    = RECIP_W / 2;
  localparam int PART_W    = M_W + HALF_W;
  localparam int SUM_W     = M_W + RECIP_W;
  localparam int ROUND_SHIFT = 33;
  localparam int R_W       = SUM_W - ROUND_SHIFT;

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [CENTER_W-1:0] CENTER_X_RST  = CENTER_W'(639);
  localparam logic [CENTER_W-1:0] CENTER_Y_RST  = CENTER_W'(479);
  localparam logic [RECIP_W-1:0]  INV_FOCAL_RST = RECIP_W'(7530512);
  localparam logic [SCALE_W-1:0]  SCALE_RST     = SCALE_W'(4294967);

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_DEPTH_SCALE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x_half;
    logic [CENTER_W-1:0] center_y_half;
    logic [RECIP_W-1:0]  inv_focal_x;
    logic [RECIP_W-1:0]  inv_focal_y;
    logic [SCALE_W-1:0]  depth_scale;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/dp3d_pixel_if.sv =====
// Input channel carrying one depth pixel item.
interface dp3d_pixel_if;
  import dp3d_pkg::*;

  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_raw;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;

  modport source (output valid, depth_raw, pixel_col, pixel_row, input ready);
  modport sink (input valid, depth_raw, pixel_col, pixel_row, output ready);
endinterface

// ===== hw/rtl/dp3d_point_if.sv =====
// Output channel carrying one 3-D point item.
interface dp3d_point_if;
  import dp3d_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [XY_W-1:0] point_x;
  logic signed [XY_W-1:0] point_y;
  logic [Z_W-1:0]         point_z;
  logic [DEPTH_W-1:0]     intensity;

  modport source (output valid, point_x, point_y, point_z, intensity, input ready);
  modport sink (input valid, point_x, point_y, point_z, intensity, output ready);
endinterface

// ===== hw/rtl/dp3d_cfg.sv =====
// APB register file holding camera intrinsics and depth scale.
module dp3d_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dp3d_pkg::PADDR_W-1:0]  paddr,
  input  logic [dp3d_pkg::PDATA_W-1:0]  pwdata,
  output logic [dp3d_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output dp3d_pkg::cfg_t                cfg
);
  import dp3d_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x_half <= CENTER_X_RST;
      cfg.center_y_half <= CENTER_Y_RST;
      cfg.inv_focal_x   <= INV_FOCAL_RST;
      cfg.inv_focal_y   <= INV_FOCAL_RST;
      cfg.depth_scale   <= SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_CENTER_X:    cfg.center_x_half <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:    cfg.center_y_half <= pwdata[CENTER_W-1:0];
        REG_INV_FOCAL_X: cfg.inv_focal_x   <= pwdata[RECIP_W-1:0];
        REG_INV_FOCAL_Y: cfg.inv_focal_y   <= pwdata[RECIP_W-1:0];
        REG_DEPTH_SCALE: cfg.depth_scale   <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X:    prdata = PDATA_W'(cfg.center_x_half);
      REG_CENTER_Y:    prdata = PDATA_W'(cfg.center_y_half);
      REG_INV_FOCAL_X: prdata = PDATA_W'(cfg.inv_focal_x);
      REG_INV_FOCAL_Y: prdata = PDATA_W'(cfg.inv_focal_y);
      REG_DEPTH_SCALE: prdata = PDATA_W'(cfg.depth_scale);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dp3d_axis.sv =====
// Five-stage projection of one image axis: offset, scale by z, reciprocal focal, round, saturate.
module dp3d_axis (
  input  logic                              clk,
  input  dp3d_pkg::pipe_ctl_t               ctl,
  input  logic [dp3d_pkg::COORD_W-1:0]      coord,
  input  logic [dp3d_pkg::CENTER_W-1:0]     center,
  input  logic [dp3d_pkg::RECIP_W-1:0]      inv_f,
  input  logic [dp3d_pkg::Z_W-1:0]          z,
  output logic signed [dp3d_pkg::XY_W-1:0]  point
);
  import dp3d_pkg::*;

  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [R_W-1:0]   R_MAX_NEG = R_W'(1) << (XY_W - 1);
  localparam logic [R_W-1:0]   R_MAX_POS = R_MAX_NEG - R_W'(1);

  logic [COORD_W-1:0] coord_m;
  logic [DIFF_W-1:0]  diff;
  logic [MAG_W-1:0]   mag_next;

  logic [MAG_W-1:0]   mag1;
  logic [M_W-1:0]     m2;
  logic [PART_W-1:0]  a3;
  logic [PART_W-1:0]  b3;
  logic [SUM_W-1:0]   sum;
  logic [R_W-1:0]     r4;
  logic [R_W-1:0]     r_sat;
  logic [NUM_STAGES-2:0] neg;

  assign coord_m  = coord & COORD_MASK;
  assign diff     = DIFF_W'({coord_m, 1'b0}) - DIFF_W'(center);
  assign mag_next = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign sum = (SUM_W'(a3) << HALF_W) + SUM_W'(b3) + ROUND_ADD;

  always_comb begin
    if (neg[3]) begin
      r_sat = (r4 > R_MAX_NEG) ? R_MAX_NEG : r4;
    end else begin
      r_sat = (r4 > R_MAX_POS) ? R_MAX_POS : r4;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      mag1   <= mag_next;
      neg[0] <= diff[DIFF_W-1];
    end
    if (ctl.load[1]) begin
      m2     <= M_W'(mag1) * M_W'(z);
      neg[1] <= neg[0];
    end
    if (ctl.load[2]) begin
      a3     <= PART_W'(m2) * PART_W'(inv_f[RECIP_W-1:HALF_W]);
      b3     <= PART_W'(m2) * PART_W'(inv_f[HALF_W-1:0]);
      neg[2] <= neg[1];
    end
    if (ctl.load[3]) begin
      r4     <= sum[SUM_W-1:ROUND_SHIFT];
      neg[3] <= neg[2];
    end
    if (ctl.load[4]) begin
      point <= neg[3] ? -XY_W'(r_sat) : XY_W'(r_sat);
    end
  end

endmodule

// ===== hw/rtl/depth_pixel_to_3d_point.sv =====
// Depth pixel back-projection top level: pipeline control, depth scaling and APB registers.
// Throughput: one item per cycle while the point channel is ready; each of the five
// stages holds one item and advances when the stage after it is empty or moving,
// so the point channel stall only backs up.
// Reset: rst clears all stage valid bits and loads the registers with their reset values.
module depth_pixel_to_3d_point (
  input  logic                          clk,
  input  logic                          rst,
  dp3d_pixel_if.sink                    pixel,
  dp3d_point_if.source                  point,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dp3d_pkg::PADDR_W-1:0]  paddr,
  input  logic [dp3d_pkg::PDATA_W-1:0]  pwdata,
  output logic [dp3d_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dp3d_pkg::*;

  cfg_t      cfg;
  pipe_ctl_t ctl;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] v_next;
  logic [NUM_STAGES:0]   rdy;

  logic [PROD_W-1:0] zprod;
  logic [ZP_W-1:0]   zp;
  logic [Z_W-1:0]    z_next;

  logic [Z_W-1:0]     z [NUM_STAGES];
  logic [DEPTH_W-1:0] inten [NUM_STAGES];

  logic signed [XY_W-1:0] x5;
  logic signed [XY_W-1:0] y5;

  dp3d_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    rdy[NUM_STAGES] = point.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    ctl.load[0] = pixel.valid && rdy[0];
    v_next[0]   = rdy[0] ? pixel.valid : v[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      ctl.load[i] = v[i-1] && rdy[i];
      v_next[i]   = rdy[i] ? v[i-1] : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign pixel.ready = rdy[0];

  assign zprod  = PROD_W'(pixel.depth_raw) * PROD_W'(cfg.depth_scale)
                + (PROD_W'(1) << (Z_SHIFT - 1));
  assign zp     = zprod[PROD_W-1:Z_SHIFT];
  assign z_next = (zp[ZP_W-1:Z_W] != '0) ? {Z_W{1'b1}} : zp[Z_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      z[0]     <= z_next;
      inten[0] <= pixel.depth_raw;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.load[i]) begin
        z[i]     <= z[i-1];
        inten[i] <= inten[i-1];
      end
    end
  end

  dp3d_axis u_axis_x (
    .clk    (clk),
    .ctl    (ctl),
    .coord  (pixel.pixel_col),
    .center (cfg.center_x_half),
    .inv_f  (cfg.inv_focal_x),
    .z      (z[0]),
    .point  (x5)
  );

  dp3d_axis u_axis_y (
    .clk    (clk),
    .ctl    (ctl),
    .coord  (pixel.pixel_row),
    .center (cfg.center_y_half),
    .inv_f  (cfg.inv_focal_y),
    .z      (z[0]),
    .point  (y5)
  );

  assign point.valid     = v[NUM_STAGES-1];
  assign point.point_x   = x5;
  assign point.point_y   = y5;
  assign point.point_z   = z[NUM_STAGES-1];
  assign point.intensity = inten[NUM_STAGES-1];

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> v[0])
    else $error("accepted item did not enter the first stage");

  a_empty_first_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> pixel.ready)
    else $error("input stalled with the first stage empty");

  a_zero_depth_zero_z: assert property (@(posedge clk) disable iff (rst)
    point.valid && (point.intensity == '0) |-> (point.point_z == '0))
    else $error("zero depth gave nonzero z");

  a_zero_z_origin: assert property (@(posedge clk) disable iff (rst)
    point.valid && (point.point_z == '0) |-> (point.point_x == '0) && (point.point_y == '0))
    else $error("zero z gave a point off the origin");

endmodule
